// ----- design/radio_link_failsafe_supervisor_assert.svh -----
// Assertion macros used by the supervisor RTL.
`ifndef RADIO_LINK_FAILSAFE_SUPERVISOR_ASSERT_SVH
`define RADIO_LINK_FAILSAFE_SUPERVISOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLFS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlfs check failed");

// Consequent must hold in the cycle after the antecedent.
`define RLFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlfs check failed");

`endif

// ----- design/rlfs_pkg.sv -----
package rlfs_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned MOTION_W   = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PULSE_W-1:0]   pulse_t;
  typedef logic [MOTION_W-1:0]  motion_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cnt_t CNT_MAX = '1;

  // Register indexes
  localparam cfg_idx_t CFG_IMMEDIATE_TICKS        = 3'd0;
  localparam cfg_idx_t CFG_AUTOPILOT_TICKS        = 3'd1;
  localparam cfg_idx_t CFG_RECOVER_ARMED_TICKS    = 3'd2;
  localparam cfg_idx_t CFG_RECOVER_DISARMED_TICKS = 3'd3;
  localparam cfg_idx_t CFG_MOTION_THRESHOLD       = 3'd4;
  localparam cfg_idx_t CFG_STICK_CENTER           = 3'd5;
  localparam cfg_idx_t CFG_GOOD_BEEP_TICKS        = 3'd6;
  localparam cfg_idx_t CFG_ALARM_BEEP_TICKS       = 3'd7;

  // Reset values
  localparam cnt_t    RST_IMMEDIATE_TICKS        = 16'd12;
  localparam cnt_t    RST_AUTOPILOT_TICKS        = 16'd50;
  localparam cnt_t    RST_RECOVER_ARMED_TICKS    = 16'd750;
  localparam cnt_t    RST_RECOVER_DISARMED_TICKS = 16'd100;
  localparam motion_t RST_MOTION_THRESHOLD       = 14'd50;
  localparam pulse_t  RST_STICK_CENTER           = 12'd1500;
  localparam cnt_t    RST_GOOD_BEEP_TICKS        = 16'd100;
  localparam cnt_t    RST_ALARM_BEEP_TICKS       = 16'd150;

  typedef struct packed {
    cnt_t    immediate_ticks;
    cnt_t    autopilot_ticks;
    cnt_t    recover_armed_ticks;
    cnt_t    recover_disarmed_ticks;
    motion_t motion_threshold;
    pulse_t  stick_center;
    cnt_t    good_beep_ticks;
    cnt_t    alarm_beep_ticks;
  } cfg_t;

  typedef struct packed {
    cnt_t loss_count;
    cnt_t recover_count;
    cnt_t beep_count;
    logic fast_flag;
    logic event_flag;
    logic good_beep_pending;
  } state_t;

  typedef struct packed {
    logic   frame_seen;
    logic   armed;
    pulse_t roll_pulse;
    pulse_t pitch_pulse;
    pulse_t yaw_pulse;
    logic   beeper_free;
    logic   gyro_calibrating;
    logic   home_switch;
  } item_t;

  typedef struct packed {
    logic immediate_failsafe;
    logic failsafe_active;
    logic force_overrides;
    logic release_home_mode;
    logic play_good_beep;
    logic play_alarm_beep;
  } res_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : cnt_t'(v + 1'b1);
  endfunction

  function automatic pulse_t abs_dev(input pulse_t p, input pulse_t c);
    return (p >= c) ? pulse_t'(p - c) : pulse_t'(c - p);
  endfunction

endpackage

// ----- design/rlfs_step.sv -----
// One tick of the supervisor: next state and result from current state and request.
module rlfs_step (
  input  rlfs_pkg::cfg_t   cfg,
  input  rlfs_pkg::state_t st,
  input  rlfs_pkg::item_t  item,
  output rlfs_pkg::state_t st_nxt,
  output rlfs_pkg::res_t   res
);

  rlfs_pkg::cnt_t    loss0;
  rlfs_pkg::cnt_t    limit;
  rlfs_pkg::motion_t dev_sum;
  logic              reached;
  logic              motion_ok;
  logic              recover;

  assign loss0 = item.frame_seen ? '0 : st.loss_count;
  assign limit = item.armed ? cfg.recover_armed_ticks : cfg.recover_disarmed_ticks;
  assign reached = st.recover_count >= limit;
  assign dev_sum =
    {2'b00, rlfs_pkg::abs_dev(item.roll_pulse,  cfg.stick_center)} +
    {2'b00, rlfs_pkg::abs_dev(item.pitch_pulse, cfg.stick_center)} +
    {2'b00, rlfs_pkg::abs_dev(item.yaw_pulse,   cfg.stick_center)};
  assign motion_ok = dev_sum >= cfg.motion_threshold;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    recover = 1'b0;

    if (loss0 > cfg.immediate_ticks) begin
      st_nxt.fast_flag = 1'b1;
    end

    if (loss0 > cfg.autopilot_ticks) begin
      st_nxt.event_flag   = 1'b1;
      res.force_overrides = 1'b1;
    end else if (st.event_flag) begin
      if (!reached) begin
        st_nxt.recover_count = rlfs_pkg::sat_inc(st.recover_count);
      end
      // armed recovery also needs the pilot to move the sticks
      recover = reached && (!item.armed || motion_ok);
      if (recover) begin
        st_nxt.fast_flag         = 1'b0;
        st_nxt.event_flag        = 1'b0;
        st_nxt.recover_count     = '0;
        st_nxt.beep_count        = '0;
        st_nxt.good_beep_pending = 1'b1;
        res.release_home_mode    = !item.home_switch;
      end
    end

    st_nxt.loss_count = rlfs_pkg::sat_inc(loss0);

    if (st_nxt.recover_count == '0 && !st_nxt.event_flag && st_nxt.good_beep_pending) begin
      if (st_nxt.beep_count >= cfg.good_beep_ticks) begin
        res.play_good_beep       = 1'b1;
        st_nxt.beep_count        = '0;
        st_nxt.good_beep_pending = 1'b0;
      end else begin
        st_nxt.beep_count = rlfs_pkg::sat_inc(st_nxt.beep_count);
      end
    end

    if (st_nxt.event_flag && item.beeper_free && !item.gyro_calibrating) begin
      if (st_nxt.beep_count >= cfg.alarm_beep_ticks) begin
        res.play_alarm_beep = 1'b1;
      end else begin
        st_nxt.beep_count = rlfs_pkg::sat_inc(st_nxt.beep_count);
      end
    end

    res.immediate_failsafe = st_nxt.fast_flag;
    res.failsafe_active    = st_nxt.event_flag;
  end

endmodule

// ----- design/radio_link_failsafe_supervisor.sv -----
// Result path: a request is taken into the input register, then its result into the result register.
// Throughput: one request per cycle while in_stall is low; the tick logic sits between the two registers.
// in_stall rises only when the input register is full and the result register is stalled.
// Reset (rst_n low, synchronous) clears all counters, flags and valids and loads
// the register defaults 12, 50, 750, 100, 50, 1500, 100, 150.
`include "radio_link_failsafe_supervisor_assert.svh"

module radio_link_failsafe_supervisor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_frame_seen,
  input  logic        in_armed,
  input  logic [11:0] in_roll_pulse,
  input  logic [11:0] in_pitch_pulse,
  input  logic [11:0] in_yaw_pulse,
  input  logic        in_beeper_free,
  input  logic        in_gyro_calibrating,
  input  logic        in_home_switch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_immediate_failsafe,
  output logic        out_failsafe_active,
  output logic        out_force_overrides,
  output logic        out_release_home_mode,
  output logic        out_play_good_beep,
  output logic        out_play_alarm_beep
);

  rlfs_pkg::cfg_t   cfg_r;
  rlfs_pkg::state_t st_r;
  rlfs_pkg::state_t st_nxt;
  rlfs_pkg::item_t  s1_item_r;
  rlfs_pkg::res_t   res_nxt;
  rlfs_pkg::res_t   out_res_r;
  logic             s1_valid_r;
  logic             out_valid_r;
  logic             out_free;
  logic             advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.immediate_ticks        <= rlfs_pkg::RST_IMMEDIATE_TICKS;
      cfg_r.autopilot_ticks        <= rlfs_pkg::RST_AUTOPILOT_TICKS;
      cfg_r.recover_armed_ticks    <= rlfs_pkg::RST_RECOVER_ARMED_TICKS;
      cfg_r.recover_disarmed_ticks <= rlfs_pkg::RST_RECOVER_DISARMED_TICKS;
      cfg_r.motion_threshold       <= rlfs_pkg::RST_MOTION_THRESHOLD;
      cfg_r.stick_center           <= rlfs_pkg::RST_STICK_CENTER;
      cfg_r.good_beep_ticks        <= rlfs_pkg::RST_GOOD_BEEP_TICKS;
      cfg_r.alarm_beep_ticks       <= rlfs_pkg::RST_ALARM_BEEP_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlfs_pkg::CFG_IMMEDIATE_TICKS:        cfg_r.immediate_ticks        <= cfg_wdata;
        rlfs_pkg::CFG_AUTOPILOT_TICKS:        cfg_r.autopilot_ticks        <= cfg_wdata;
        rlfs_pkg::CFG_RECOVER_ARMED_TICKS:    cfg_r.recover_armed_ticks    <= cfg_wdata;
        rlfs_pkg::CFG_RECOVER_DISARMED_TICKS: cfg_r.recover_disarmed_ticks <= cfg_wdata;
        rlfs_pkg::CFG_MOTION_THRESHOLD:
          cfg_r.motion_threshold <= cfg_wdata[rlfs_pkg::MOTION_W-1:0];
        rlfs_pkg::CFG_STICK_CENTER:
          cfg_r.stick_center <= cfg_wdata[rlfs_pkg::PULSE_W-1:0];
        rlfs_pkg::CFG_GOOD_BEEP_TICKS:        cfg_r.good_beep_ticks        <= cfg_wdata;
        rlfs_pkg::CFG_ALARM_BEEP_TICKS:       cfg_r.alarm_beep_ticks       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: take a request whenever it is empty or draining this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r.frame_seen       <= in_frame_seen;
      s1_item_r.armed            <= in_armed;
      s1_item_r.roll_pulse       <= in_roll_pulse;
      s1_item_r.pitch_pulse      <= in_pitch_pulse;
      s1_item_r.yaw_pulse        <= in_yaw_pulse;
      s1_item_r.beeper_free      <= in_beeper_free;
      s1_item_r.gyro_calibrating <= in_gyro_calibrating;
      s1_item_r.home_switch      <= in_home_switch;
    end
  end

  rlfs_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Advance supervisor state only when the tick moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_immediate_failsafe = out_res_r.immediate_failsafe;
  assign out_failsafe_active    = out_res_r.failsafe_active;
  assign out_force_overrides    = out_res_r.force_overrides;
  assign out_release_home_mode  = out_res_r.release_home_mode;
  assign out_play_good_beep     = out_res_r.play_good_beep;
  assign out_play_alarm_beep    = out_res_r.play_alarm_beep;

  `RLFS_ASSERT_SAME(a_force_latches, out_valid_r && out_res_r.force_overrides, out_res_r.failsafe_active)
  `RLFS_ASSERT_SAME(a_beeps_exclusive, out_valid_r, !(out_res_r.play_good_beep && out_res_r.play_alarm_beep))
  `RLFS_ASSERT_SAME(a_release_clears, out_valid_r && out_res_r.release_home_mode, !out_res_r.failsafe_active && !out_res_r.immediate_failsafe)
  `RLFS_ASSERT_NEXT(a_state_held, !advance, st_r == $past(st_r))

endmodule

// ----- verif/tb_radio_link_failsafe_supervisor.sv -----
`timescale 1ns / 100ps

module tb_radio_link_failsafe_supervisor;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_TICKS = 115;

  typedef enum int {
    IDLE_RECV_SLOW,
    IDLE_SEND_SLOW,
    IDLE_NONE
  } idle_mode_t;

  // Mirrors the supervisor tick by tick and holds the flags it should report.
  class failsafe_scoreboard;
    rlfs_pkg::cfg_t   regs;
    rlfs_pkg::cnt_t   loss_cnt;
    rlfs_pkg::cnt_t   recover_cnt;
    rlfs_pkg::cnt_t   beep_cnt;
    bit               fast;
    bit               failsafe;
    bit               good_pending;
    bit               disarmed_done;
    rlfs_pkg::res_t   expected_flags[$];
    int               failures;

    function new();
      regs.immediate_ticks        = rlfs_pkg::RST_IMMEDIATE_TICKS;
      regs.autopilot_ticks        = rlfs_pkg::RST_AUTOPILOT_TICKS;
      regs.recover_armed_ticks    = rlfs_pkg::RST_RECOVER_ARMED_TICKS;
      regs.recover_disarmed_ticks = rlfs_pkg::RST_RECOVER_DISARMED_TICKS;
      regs.motion_threshold       = rlfs_pkg::RST_MOTION_THRESHOLD;
      regs.stick_center           = rlfs_pkg::RST_STICK_CENTER;
      regs.good_beep_ticks        = rlfs_pkg::RST_GOOD_BEEP_TICKS;
      regs.alarm_beep_ticks       = rlfs_pkg::RST_ALARM_BEEP_TICKS;
      loss_cnt      = '0;
      recover_cnt   = '0;
      beep_cnt      = '0;
      fast          = 1'b0;
      failsafe      = 1'b0;
      good_pending  = 1'b0;
      disarmed_done = 1'b0;
      failures      = 0;
    endfunction

    function void write_reg(rlfs_pkg::cfg_idx_t idx, logic [15:0] v);
      case (idx)
        rlfs_pkg::CFG_IMMEDIATE_TICKS:        regs.immediate_ticks = v;
        rlfs_pkg::CFG_AUTOPILOT_TICKS:        regs.autopilot_ticks = v;
        rlfs_pkg::CFG_RECOVER_ARMED_TICKS:    regs.recover_armed_ticks = v;
        rlfs_pkg::CFG_RECOVER_DISARMED_TICKS: regs.recover_disarmed_ticks = v;
        rlfs_pkg::CFG_MOTION_THRESHOLD:       regs.motion_threshold = v[rlfs_pkg::MOTION_W-1:0];
        rlfs_pkg::CFG_STICK_CENTER:           regs.stick_center = v[rlfs_pkg::PULSE_W-1:0];
        rlfs_pkg::CFG_GOOD_BEEP_TICKS:        regs.good_beep_ticks = v;
        rlfs_pkg::CFG_ALARM_BEEP_TICKS:       regs.alarm_beep_ticks = v;
        default: ;
      endcase
    endfunction

    function rlfs_pkg::cnt_t bump(rlfs_pkg::cnt_t v);
      return v + rlfs_pkg::cnt_t'(v != rlfs_pkg::CNT_MAX);
    endfunction

    function int offset(rlfs_pkg::pulse_t p);
      return int'((p >= regs.stick_center) ? p - regs.stick_center : regs.stick_center - p);
    endfunction

    function void note_tick(rlfs_pkg::item_t t);
      rlfs_pkg::res_t r;
      bit             recover;
      int             swing;
      r = '0;
      recover = 1'b0;
      if (t.frame_seen) loss_cnt = '0;
      if (loss_cnt > regs.immediate_ticks) fast = 1'b1;
      if (loss_cnt > regs.autopilot_ticks) begin
        failsafe = 1'b1;
        r.force_overrides = 1'b1;
      end else if (failsafe) begin
        if (t.armed) begin
          if (recover_cnt >= regs.recover_armed_ticks) begin
            swing = offset(t.roll_pulse) + offset(t.pitch_pulse) + offset(t.yaw_pulse);
            recover = (swing >= int'(regs.motion_threshold));
          end else begin
            recover_cnt = bump(recover_cnt);
          end
        end else if (!disarmed_done) begin
          if (recover_cnt >= regs.recover_disarmed_ticks) begin
            disarmed_done = 1'b1;
            recover = 1'b1;
          end else begin
            recover_cnt = bump(recover_cnt);
            disarmed_done = 1'b0;
          end
        end
        if (recover) begin
          fast = 1'b0;
          failsafe = 1'b0;
          r.release_home_mode = !t.home_switch;
          recover_cnt = '0;
          beep_cnt = '0;
          good_pending = 1'b1;
          disarmed_done = 1'b0;
        end
      end
      loss_cnt = bump(loss_cnt);
      if (recover_cnt == '0 && !failsafe && good_pending) begin
        if (beep_cnt >= regs.good_beep_ticks) begin
          r.play_good_beep = 1'b1;
          beep_cnt = '0;
          good_pending = 1'b0;
        end else begin
          beep_cnt = bump(beep_cnt);
        end
      end
      // alarm keeps sounding once the count has reached the threshold
      if (failsafe && t.beeper_free && !t.gyro_calibrating) begin
        if (beep_cnt >= regs.alarm_beep_ticks) r.play_alarm_beep = 1'b1;
        else beep_cnt = bump(beep_cnt);
      end
      r.immediate_failsafe = fast;
      r.failsafe_active = failsafe;
      expected_flags.push_back(r);
    endfunction

    function void compare_flag(string field, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, got %0b", field, want, got);
        failures++;
      end
    endfunction

    function void check_flags(rlfs_pkg::res_t got);
      rlfs_pkg::res_t want;
      if (expected_flags.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      want = expected_flags.pop_front();
      compare_flag("immediate_failsafe", want.immediate_failsafe, got.immediate_failsafe);
      compare_flag("failsafe_active", want.failsafe_active, got.failsafe_active);
      compare_flag("force_overrides", want.force_overrides, got.force_overrides);
      compare_flag("release_home_mode", want.release_home_mode, got.release_home_mode);
      compare_flag("play_good_beep", want.play_good_beep, got.play_good_beep);
      compare_flag("play_alarm_beep", want.play_alarm_beep, got.play_alarm_beep);
    endfunction

    function int outstanding();
      return expected_flags.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  rlfs_pkg::cfg_idx_t cfg_index = rlfs_pkg::CFG_IMMEDIATE_TICKS;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_frame_seen = 1'b0;
  logic               in_armed = 1'b0;
  rlfs_pkg::pulse_t   in_roll_pulse = '0;
  rlfs_pkg::pulse_t   in_pitch_pulse = '0;
  rlfs_pkg::pulse_t   in_yaw_pulse = '0;
  logic               in_beeper_free = 1'b0;
  logic               in_gyro_calibrating = 1'b0;
  logic               in_home_switch = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_immediate_failsafe;
  logic               out_failsafe_active;
  logic               out_force_overrides;
  logic               out_release_home_mode;
  logic               out_play_good_beep;
  logic               out_play_alarm_beep;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  failsafe_scoreboard sb;

  radio_link_failsafe_supervisor uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_frame_seen          (in_frame_seen),
    .in_armed               (in_armed),
    .in_roll_pulse          (in_roll_pulse),
    .in_pitch_pulse         (in_pitch_pulse),
    .in_yaw_pulse           (in_yaw_pulse),
    .in_beeper_free         (in_beeper_free),
    .in_gyro_calibrating    (in_gyro_calibrating),
    .in_home_switch         (in_home_switch),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_immediate_failsafe (out_immediate_failsafe),
    .out_failsafe_active    (out_failsafe_active),
    .out_force_overrides    (out_force_overrides),
    .out_release_home_mode  (out_release_home_mode),
    .out_play_good_beep     (out_play_good_beep),
    .out_play_alarm_beep    (out_play_alarm_beep)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: random stall, or a long hold-off on request so the pipe backs up.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_flags({out_immediate_failsafe, out_failsafe_active, out_force_overrides,
                      out_release_home_mode, out_play_good_beep, out_play_alarm_beep});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_RECV_SLOW: begin send_idle_pct = 26; recv_idle_pct = 72; end
      IDLE_SEND_SLOW: begin send_idle_pct = 72; recv_idle_pct = 26; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  task automatic write_reg(rlfs_pkg::cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] imm, logic [15:0] ap, logic [15:0] rarm,
                            logic [15:0] rdis, logic [15:0] motion, logic [15:0] centre,
                            logic [15:0] good, logic [15:0] alarm);
    write_reg(rlfs_pkg::CFG_IMMEDIATE_TICKS, imm);
    write_reg(rlfs_pkg::CFG_AUTOPILOT_TICKS, ap);
    write_reg(rlfs_pkg::CFG_RECOVER_ARMED_TICKS, rarm);
    write_reg(rlfs_pkg::CFG_RECOVER_DISARMED_TICKS, rdis);
    write_reg(rlfs_pkg::CFG_MOTION_THRESHOLD, motion);
    write_reg(rlfs_pkg::CFG_STICK_CENTER, centre);
    write_reg(rlfs_pkg::CFG_GOOD_BEEP_TICKS, good);
    write_reg(rlfs_pkg::CFG_ALARM_BEEP_TICKS, alarm);
    cfg_we <= 1'b0;
  endtask

  task automatic send_tick(rlfs_pkg::item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_seen <= t.frame_seen;
    in_armed <= t.armed;
    in_roll_pulse <= t.roll_pulse;
    in_pitch_pulse <= t.pitch_pulse;
    in_yaw_pulse <= t.yaw_pulse;
    in_beeper_free <= t.beeper_free;
    in_gyro_calibrating <= t.gyro_calibrating;
    in_home_switch <= t.home_switch;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
  endtask

  task automatic tick(bit frame, bit armed, rlfs_pkg::pulse_t roll, rlfs_pkg::pulse_t pitch,
                      rlfs_pkg::pulse_t yaw, bit free, bit cal, bit home);
    send_tick('{frame, armed, roll, pitch, yaw, free, cal, home});
  endtask

  // Let every outstanding request come back before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic rlfs_pkg::pulse_t pick_pulse();
    int c;
    int v;
    c = int'(sb.regs.stick_center);
    case ($urandom_range(3))
      0: return rlfs_pkg::pulse_t'($urandom_range(4095));
      1: begin
        v = c - 200 + int'($urandom_range(400));
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return rlfs_pkg::pulse_t'(v);
      end
      2: return $urandom_range(1) ? 12'hFFF : 12'h000;
      default: return rlfs_pkg::pulse_t'(c);
    endcase
  endfunction

  function automatic rlfs_pkg::item_t make_tick(bit frame, bit armed);
    rlfs_pkg::item_t t;
    t.frame_seen = frame;
    t.armed = armed;
    t.roll_pulse = pick_pulse();
    t.pitch_pulse = pick_pulse();
    t.yaw_pulse = pick_pulse();
    t.beeper_free = ($urandom_range(4) != 0);
    t.gyro_calibrating = ($urandom_range(6) == 0);
    t.home_switch = 1'($urandom_range(1));
    return t;
  endfunction

  // Episodes of link loss around the thresholds followed by a good stretch.
  task automatic random_phase(int quota);
    int sent;
    int lost;
    int good;
    int ap;
    int imm;
    int cap;
    bit arm;
    bit noise;
    sent = 0;
    while (sent < quota) begin
      ap = (sb.regs.autopilot_ticks > 16'd30) ? 30 : int'(sb.regs.autopilot_ticks);
      imm = (sb.regs.immediate_ticks > 16'd30) ? 30 : int'(sb.regs.immediate_ticks);
      cap = int'(sb.regs.recover_armed_ticks) + int'(sb.regs.recover_disarmed_ticks)
            + int'(sb.regs.good_beep_ticks) + 4;
      if (cap > 30) cap = 30;
      case ($urandom_range(3))
        0: lost = int'($urandom_range(3));
        1: lost = ap + int'($urandom_range(3));
        2: lost = imm + int'($urandom_range(2));
        default: lost = int'($urandom_range(12));
      endcase
      good = 1 + int'($urandom_range(cap));
      arm = 1'($urandom_range(1));
      noise = ($urandom_range(9) == 0);
      for (int i = 0; i < lost; i++)
        send_tick(make_tick(noise ? 1'($urandom_range(1)) : ($urandom_range(9) == 0),
                            arm ^ ($urandom_range(9) == 0)));
      for (int i = 0; i < good; i++)
        send_tick(make_tick(noise ? 1'($urandom_range(1)) : ($urandom_range(19) != 0),
                            arm ^ ($urandom_range(9) == 0)));
      sent += lost + good;
    end
  endtask

  initial begin
    sb = new();
    set_idle(IDLE_RECV_SLOW);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults straight after reset, pulses mostly at their extremes
    tick(1, 0, 12'h000, 12'hFFF, 12'd1500, 1, 0, 0);
    tick(0, 1, 12'hFFF, 12'h000, 12'h000, 0, 1, 1);
    tick(1, 1, 12'hAAA, 12'h555, 12'hFFF, 1, 1, 1);
    drain();

    set_config(16'd1, 16'd2, 16'd1, 16'd1, 16'd100, 16'd1500, 16'd1, 16'd1);
    tick(1, 0, 12'd1500, 12'd1500, 12'd1500, 1, 0, 0);
    // lose the link: fast failsafe, then the latched one with overrides
    repeat (4) tick(0, 0, 12'd1500, 12'd1500, 12'd1500, 1, 0, 0);
    tick(0, 0, 12'd1500, 12'd1500, 12'd1500, 0, 0, 0);
    tick(0, 1, 12'd1500, 12'd1500, 12'd1500, 1, 1, 0);
    // armed: sticks centred hold the failsafe, a big deflection ends it
    tick(1, 1, 12'd1500, 12'd1500, 12'd1500, 1, 0, 0);
    tick(1, 1, 12'd1500, 12'd1500, 12'd1500, 1, 0, 0);
    tick(1, 1, 12'hFFF, 12'h000, 12'd1500, 1, 0, 1);
    repeat (3) tick(1, 1, 12'd1500, 12'd1500, 12'd1500, 1, 0, 0);
    // disarmed recovery with the home switch off releases return-home
    repeat (4) tick(0, 0, 12'h555, 12'hAAA, 12'd1500, 1, 0, 0);
    tick(1, 0, 12'd1500, 12'd1500, 12'd1500, 1, 0, 0);
    tick(1, 0, 12'd1500, 12'd1500, 12'd1500, 1, 0, 0);
    repeat (3) tick(1, 0, 12'hFFF, 12'hFFF, 12'hFFF, 1, 0, 0);
    drain();

    set_config(16'd2, 16'd5, 16'd4, 16'd3, 16'd300, 16'd1500, 16'd3, 16'd4);
    random_phase(PHASE_TICKS);
    drain();
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(PHASE_TICKS);
    drain();

    set_idle(IDLE_SEND_SLOW);
    set_config(16'd4, 16'd3, 16'd2, 16'd6, 16'hFFFF, 16'd4095, 16'd1, 16'hFFFF);
    random_phase(PHASE_TICKS);
    drain();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16383, 16'd4095,
               16'hFFFF, 16'hFFFF);
    random_phase(PHASE_TICKS);
    drain();

    set_idle(IDLE_NONE);
    set_config(16'd1, 16'd8, 16'd10, 16'd10, 16'd1000, 16'd2048, 16'd6, 16'd2);
    hold_request = 1'b1;
    random_phase(PHASE_TICKS);
    drain();
    set_config(16'd3, 16'd12, 16'd20, 16'd15, 16'd600, 16'd1000, 16'd10, 16'd8);
    random_phase(PHASE_TICKS);
    drain();

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- radio_link_failsafe_supervisor.f -----
+incdir+design
design/rlfs_pkg.sv
design/rlfs_step.sv
design/radio_link_failsafe_supervisor.sv
verif/tb_radio_link_failsafe_supervisor.sv
